[design/wct_pkg.sv]
// Shared types and constants of the windowed corner turn.
package wct_pkg;

	localparam int MaxSamples = 256;
	localparam int MaxChirps  = 128;
	localparam int SmpW       = $clog2(MaxSamples);
	localparam int ChpW       = $clog2(MaxChirps);
	localparam int AddrW      = SmpW + ChpW;
	localparam int PlaneDepth = MaxSamples * MaxChirps;

	localparam int SpcW = 9;
	localparam int CpfW = 8;
	localparam int CfgW = 9;
	localparam int CfgIdxW = 2;

	// Register indexes of the configuration port.
	localparam logic [CfgIdxW-1:0] CFG_SAMPLES = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_CHIRPS  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_WINDOW  = 2'd2;

	// Input action codes.
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	// Unity weight in Q1.15.
	localparam logic [15:0] WeightOne = 16'h8000;

	typedef struct packed {
		logic               action;
		logic signed [15:0] sample_real;
		logic signed [15:0] sample_imag;
		logic        [15:0] weight;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] out_real;
		logic signed [15:0] out_imag;
		logic               out_valid;
		logic               last_of_plane;
		logic               phase_error;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept_wr;
		logic accept_rd;
		logic issue_rd;
		logic load_data;
		logic load_err;
	} cmd_t;

	typedef struct packed {
		logic reading;
	} stat_t;

endpackage

[design/wct_in_if.sv]
// Input channel: valid/ready handshake with one input word.
interface wct_in_if;
	logic              valid;
	logic              ready;
	wct_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[design/wct_out_if.sv]
// Output channel: valid/ready handshake with one result word.
interface wct_out_if;
	logic               valid;
	logic               ready;
	wct_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[design/wct_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wct_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/wct_ctrl.sv]
// Controller state machine: handshakes and sequencing of plane reads.
module wct_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_action,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  wct_pkg::stat_t  stat,
	output wct_pkg::cmd_t   cmd
);

	wct_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wct_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			wct_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_action == wct_pkg::ACT_WRITE && !stat.reading) begin
						cmd.accept_wr = 1'b1;
					end else if (in_action == wct_pkg::ACT_READ && stat.reading) begin
						cmd.accept_rd = 1'b1;
						state_d       = wct_pkg::ST_RD_ADDR;
					end else begin
						cmd.load_err = 1'b1;
						state_d      = wct_pkg::ST_OUT;
					end
				end
			end
			wct_pkg::ST_RD_ADDR: begin
				cmd.issue_rd = 1'b1;
				state_d      = wct_pkg::ST_RD_DATA;
			end
			wct_pkg::ST_RD_DATA: begin
				cmd.load_data = 1'b1;
				state_d       = wct_pkg::ST_OUT;
			end
			wct_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = wct_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wct_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[design/wct_dp.sv]
// Datapath: size registers, plane counters, window multiply and plane store.
module wct_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wct_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [wct_pkg::CfgW-1:0]     cfg_data,
	input  wct_pkg::in_word_t            in_data,
	input  wct_pkg::cmd_t                cmd,
	output wct_pkg::stat_t               stat,
	output wct_pkg::out_word_t           out_data
);

	localparam int SmpW  = wct_pkg::SmpW;
	localparam int ChpW  = wct_pkg::ChpW;
	localparam int AddrW = wct_pkg::AddrW;

	// Effective sizes minus one, clamped into range.
	logic [SmpW-1:0] ns_m1_q;
	logic [ChpW-1:0] nc_m1_q;
	logic            win_en_q;

	logic [SmpW-1:0] wr_smp_q, rd_smp_q;
	logic [ChpW-1:0] wr_chp_q, rd_chp_q;
	logic            reading_q;

	logic             rd_last;
	logic [AddrW-1:0] rd_addr_q;
	logic             rd_last_q;

	logic                wr_en_s1;
	logic [AddrW-1:0]    wr_addr_s1;
	logic signed [32:0]  prod_re_s1, prod_im_s1;

	logic [15:0]         wgt;
	logic [31:0]         ram_wdata, ram_rdata;
	wct_pkg::out_word_t  out_q;

	function automatic logic [SmpW-1:0] clamp_spc(input logic [wct_pkg::SpcW-1:0] v);
		logic [SmpW-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (v > wct_pkg::SpcW'(wct_pkg::MaxSamples)) begin
			r = SmpW'(wct_pkg::MaxSamples - 1);
		end else begin
			r = SmpW'(v - 1'b1);
		end
		return r;
	endfunction

	function automatic logic [ChpW-1:0] clamp_cpf(input logic [wct_pkg::CpfW-1:0] v);
		logic [ChpW-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if ({1'b0, v} > (wct_pkg::CpfW + 1)'(wct_pkg::MaxChirps)) begin
			r = ChpW'(wct_pkg::MaxChirps - 1);
		end else begin
			r = ChpW'(v - 1'b1);
		end
		return r;
	endfunction

	// Round half up, shift by 15 and saturate to Q1.15.
	function automatic logic [15:0] round_sat(input logic signed [32:0] p);
		logic signed [33:0] s;
		logic signed [18:0] q;
		logic [15:0]        r;
		s = {p[32], p} + 34'sd16384;
		q = s[33:15];
		if (q > 19'sd32767) begin
			r = 16'h7fff;
		end else if (q < -19'sd32768) begin
			r = 16'h8000;
		end else begin
			r = q[15:0];
		end
		return r;
	endfunction

	assign stat.reading = reading_q;
	assign rd_last      = (rd_chp_q == nc_m1_q) && (rd_smp_q == ns_m1_q);
	assign wgt          = win_en_q ? in_data.weight : wct_pkg::WeightOne;

	// Configuration and plane counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_m1_q   <= SmpW'(wct_pkg::MaxSamples - 1);
			nc_m1_q   <= ChpW'(wct_pkg::MaxChirps - 1);
			win_en_q  <= 1'b0;
			wr_smp_q  <= '0;
			wr_chp_q  <= '0;
			rd_smp_q  <= '0;
			rd_chp_q  <= '0;
			reading_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == wct_pkg::CFG_SAMPLES || cfg_index == wct_pkg::CFG_CHIRPS) begin
				if (cfg_index == wct_pkg::CFG_SAMPLES) begin
					ns_m1_q <= clamp_spc(cfg_data);
				end else begin
					nc_m1_q <= clamp_cpf(cfg_data[wct_pkg::CpfW-1:0]);
				end
				wr_smp_q  <= '0;
				wr_chp_q  <= '0;
				rd_smp_q  <= '0;
				rd_chp_q  <= '0;
				reading_q <= 1'b0;
			end else if (cfg_index == wct_pkg::CFG_WINDOW) begin
				win_en_q <= cfg_data[0];
			end
		end else if (cmd.accept_wr) begin
			if (wr_smp_q == ns_m1_q) begin
				wr_smp_q <= '0;
				if (wr_chp_q == nc_m1_q) begin
					wr_chp_q  <= '0;
					rd_smp_q  <= '0;
					rd_chp_q  <= '0;
					reading_q <= 1'b1;
				end else begin
					wr_chp_q <= wr_chp_q + 1'b1;
				end
			end else begin
				wr_smp_q <= wr_smp_q + 1'b1;
			end
		end else if (cmd.accept_rd) begin
			if (rd_last) begin
				rd_smp_q  <= '0;
				rd_chp_q  <= '0;
				wr_smp_q  <= '0;
				wr_chp_q  <= '0;
				reading_q <= 1'b0;
			end else if (rd_chp_q == nc_m1_q) begin
				rd_chp_q <= '0;
				rd_smp_q <= rd_smp_q + 1'b1;
			end else begin
				rd_chp_q <= rd_chp_q + 1'b1;
			end
		end
	end

	// Write stage: product registered, rounded on the way into the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
		end else begin
			wr_en_s1 <= cmd.accept_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_wr) begin
			wr_addr_s1 <= {wr_chp_q, wr_smp_q};
			prod_re_s1 <= in_data.sample_real * $signed({1'b0, wgt});
			prod_im_s1 <= in_data.sample_imag * $signed({1'b0, wgt});
		end
		if (cmd.accept_rd) begin
			rd_addr_q <= {rd_chp_q, rd_smp_q};
			rd_last_q <= rd_last;
		end
	end

	assign ram_wdata = {round_sat(prod_re_s1), round_sat(prod_im_s1)};

	wct_ram #(
		.Width (32),
		.Depth (wct_pkg::PlaneDepth)
	) u_plane (
		.clk   (clk),
		.we    (wr_en_s1),
		.waddr (wr_addr_s1),
		.wdata (ram_wdata),
		.re    (cmd.issue_rd),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_err) begin
			out_q.out_real      <= '0;
			out_q.out_imag      <= '0;
			out_q.out_valid     <= 1'b0;
			out_q.last_of_plane <= 1'b0;
			out_q.phase_error   <= 1'b1;
		end else if (cmd.load_data) begin
			out_q.out_real      <= ram_rdata[31:16];
			out_q.out_imag      <= ram_rdata[15:0];
			out_q.out_valid     <= 1'b1;
			out_q.last_of_plane <= rd_last_q;
			out_q.phase_error   <= 1'b0;
		end
	end

	assign out_data = out_q;

endmodule

[design/windowed_corner_turn.sv]
// Top level of the windowed corner turn: controller, datapath and channels.
//
// Corner turn of one radar antenna plane at a time. Write words (action 0)
// bring complex Q1.15 samples in chirp-major order, sample index fastest;
// with window_enable set each part is multiplied by the word's weight
// (32768 = 1.0), rounded half up and saturated, otherwise it is stored as
// given. Once samples_per_chirp * chirps_per_frame samples are in, read
// words (action 1) return the plane sample-major, chirp index fastest, with
// last_of_plane on the final element, after which loading starts again.
// A write during read-out or a read during loading is dropped and answered
// by one result word with phase_error set and all other fields zero; a
// write in the loading phase gives no result word. Size values of zero
// count as one and values above 256 samples or 128 chirps are clamped.
// Writing a size register restarts the plane; the window bit takes effect
// from the next write. Rate: a write word is taken every cycle (the weight
// product is registered and lands in the plane store in the cycle after); a
// read word or a phase error holds the input for the result; a read steps
// through accept, store address, registered store read and result register
// plus any output wait, a phase error through accept and result register.
// The plane store is one 32768-entry, 32-bit memory and needs no clearing.
module windowed_corner_turn (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [wct_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [wct_pkg::CfgW-1:0]    cfg_data,
	wct_in_if.sink                      din,
	wct_out_if.source                   dout
);

	wct_pkg::cmd_t  cmd;
	wct_pkg::stat_t stat;

	// Sequencing: accept words, step through the read of one element.
	wct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_action (din.data.action),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage, counters and the window multiply.
	wct_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (din.data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (dout.data)
	);

endmodule

[dv/windowed_corner_turn_checker.sv]
// Checker of the windowed corner turn: mirrors the plane store and compares result words.
`timescale 1ns / 1ps
module windowed_corner_turn_checker
	import wct_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data,
	wct_in_if                  din,
	wct_out_if                 dout,
	output int                 fail_count,
	output int                 pending
);

	logic [SpcW-1:0]    spc_q;
	logic [CpfW-1:0]    cpf_q;
	logic               win_q;
	logic signed [15:0] plane_re [PlaneDepth];
	logic signed [15:0] plane_im [PlaneDepth];
	int unsigned        wr_count;
	int unsigned        rd_smp;
	int unsigned        rd_chp;
	bit                 reading;
	out_word_t          awaited_words [$];

	function automatic int unsigned eff_samples();
		if (spc_q == 0) return 1;
		if (spc_q > MaxSamples) return MaxSamples;
		return spc_q;
	endfunction

	function automatic int unsigned eff_chirps();
		if (cpf_q == 0) return 1;
		if (cpf_q > MaxChirps) return MaxChirps;
		return cpf_q;
	endfunction

	// Q1.15 product, round half up, saturate to 16 bits.
	function automatic logic signed [15:0] weigh(input logic signed [15:0] x,
			input logic [15:0] w);
		longint prod;
		prod = (longint'(x) * longint'(w) + 64'sd16384) >>> 15;
		if (prod > 32767) return 16'sh7fff;
		if (prod < -32768) return 16'sh8000;
		return 16'(prod);
	endfunction

	task automatic restart_plane();
		wr_count = 0;
		rd_smp   = 0;
		rd_chp   = 0;
		reading  = 1'b0;
	endtask

	task automatic transpose_step(input in_word_t w);
		int unsigned ns;
		int unsigned nc;
		int unsigned chirp;
		int unsigned smp;
		int unsigned addr;
		bit          last;
		out_word_t   res;
		ns  = eff_samples();
		nc  = eff_chirps();
		res = '0;
		if (w.action == ACT_WRITE) begin
			if (reading) begin
				res.phase_error = 1'b1;
				awaited_words.push_back(res);
			end else begin
				chirp = wr_count / ns;
				smp   = wr_count % ns;
				if (chirp >= nc) chirp = nc - 1;
				addr = chirp * MaxSamples + smp;
				if (win_q) begin
					plane_re[addr] = weigh(w.sample_real, w.weight);
					plane_im[addr] = weigh(w.sample_imag, w.weight);
				end else begin
					plane_re[addr] = w.sample_real;
					plane_im[addr] = w.sample_imag;
				end
				wr_count++;
				if (wr_count >= ns * nc) begin
					reading = 1'b1;
					rd_smp  = 0;
					rd_chp  = 0;
				end
			end
		end else begin
			if (!reading) begin
				res.phase_error = 1'b1;
				awaited_words.push_back(res);
			end else begin
				if (rd_smp >= ns) rd_smp = ns - 1;
				if (rd_chp >= nc) rd_chp = nc - 1;
				addr = rd_chp * MaxSamples + rd_smp;
				last = (rd_chp == nc - 1) && (rd_smp == ns - 1);
				res.out_real      = plane_re[addr];
				res.out_imag      = plane_im[addr];
				res.out_valid     = 1'b1;
				res.last_of_plane = last;
				awaited_words.push_back(res);
				if (last) begin
					restart_plane();
				end else if (rd_chp + 1 >= nc) begin
					rd_chp = 0;
					rd_smp++;
				end else begin
					rd_chp++;
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	task automatic compare_word(input out_word_t got);
		out_word_t want;
		if (awaited_words.size() == 0) begin
			fail_count++;
			$display("%0t: result word with none awaited, expected none, actual %h",
				$time, got);
		end else begin
			want = awaited_words.pop_front();
			check_field("out_real", want.out_real, got.out_real);
			check_field("out_imag", want.out_imag, got.out_imag);
			check_field("out_valid", 16'(want.out_valid), 16'(got.out_valid));
			check_field("last_of_plane", 16'(want.last_of_plane), 16'(got.last_of_plane));
			check_field("phase_error", 16'(want.phase_error), 16'(got.phase_error));
		end
	endtask

	// Apply register writes first, then the accepted input word, then the result word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spc_q = SpcW'(MaxSamples);
			cpf_q = CpfW'(MaxChirps);
			win_q = 1'b0;
			restart_plane();
			awaited_words.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SAMPLES: begin
						spc_q = cfg_data[SpcW-1:0];
						restart_plane();
					end
					CFG_CHIRPS: begin
						cpf_q = cfg_data[CpfW-1:0];
						restart_plane();
					end
					CFG_WINDOW: win_q = cfg_data[0];
					default: ;
				endcase
			end
			if (din.valid && din.ready) transpose_step(din.data);
			if (dout.valid && dout.ready) compare_word(dout.data);
			pending = awaited_words.size();
		end
	end

endmodule

[dv/windowed_corner_turn_tb.sv]
// Testbench top of the windowed corner turn: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module windowed_corner_turn_tb;
	import wct_pkg::*;

	// Keep a wide margin over the slowest plausible run.
	localparam int CycleLimit   = 600000;
	localparam int RandomWords  = 1000;
	localparam int HoldCycles   = 300;
	localparam int SettleCycles = 8;
	localparam int DrainCycles  = 20;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgW-1:0]    cfg_data;

	wct_in_if  din_if ();
	wct_out_if dout_if ();

	int fail_count;
	int pending;
	int cycle_count;
	int words_sent;
	int hold_reqs  = 0;   // raised by the stimulus
	int holds_done = 0;   // served by the receiver
	bit gaps_on;
	int burst_left;
	int cur_spc;
	int cur_cpf;

	windowed_corner_turn uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.din       (din_if),
		.dout      (dout_if)
	);

	windowed_corner_turn_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.din        (din_if),
		.dout       (dout_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up if the run hangs, e.g. a result word never shows up.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: change stall pattern every stretch; serve long hold-off requests.
	initial begin : receiver
		int mode;
		int stretch;
		int period;
		int i;
		dout_if.ready = 1'b0;
		forever begin
			mode    = $urandom_range(0, 3);
			stretch = $urandom_range(20, 200);
			period  = $urandom_range(2, 7);
			for (i = 0; i < stretch; i++) begin
				@(negedge clk);
				if (hold_reqs != holds_done) begin
					// Hold off long enough that the block backs up into its input.
					dout_if.ready = 1'b0;
					repeat (HoldCycles - 1) @(negedge clk);
					holds_done++;
				end
				case (mode)
					0: dout_if.ready = 1'b1;
					1: dout_if.ready = 1'($urandom);
					2: dout_if.ready = ($urandom_range(0, 3) != 0);
					default: dout_if.ready = ((i % period) != 0);
				endcase
			end
		end
	end

	// Size as the block uses it: zero counts as one, clamp at the bound.
	function automatic int eff_size(input int v, input int hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// Sample part with extra weight on the extremes and the rounding corners.
	function automatic logic signed [15:0] any_part();
		case ($urandom_range(0, 15))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return -16'sh0001;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] any_weight();
		case ($urandom_range(0, 7))
			0: return WeightOne;
			1: return 16'd0;
			2: return 16'd16384;
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic in_word_t make_write(input logic signed [15:0] re,
			input logic signed [15:0] im, input logic [15:0] wt);
		in_word_t w;
		w.action      = ACT_WRITE;
		w.sample_real = re;
		w.sample_imag = im;
		w.weight      = wt;
		return w;
	endfunction

	function automatic in_word_t sample_word();
		return make_write(any_part(), any_part(), any_weight());
	endfunction

	// Read words carry random payload; the block must ignore it.
	function automatic in_word_t read_word();
		in_word_t w;
		w        = sample_word();
		w.action = ACT_READ;
		return w;
	endfunction

	// Offer one word, idling first when the current burst is used up.
	task automatic send_word(input in_word_t w);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				din_if.valid       = 1'b0;
				din_if.data        = sample_word();
				din_if.data.action = 1'($urandom);
			end
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) burst_left--;
		@(negedge clk);
		din_if.valid = 1'b1;
		din_if.data  = w;
		do @(posedge clk); while (din_if.ready !== 1'b1);
		words_sent++;
	endtask

	// Drop valid and wait until every awaited result word is in, then let
	// the write pipeline empty.
	task automatic settle();
		@(negedge clk);
		din_if.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
		settle();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = CfgW'(value);
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_SAMPLES) cur_spc = value;
		if (idx == CFG_CHIRPS) cur_cpf = value;
	endtask

	// Load samples; now and then slip in an out-of-phase read or retune the window.
	task automatic load_samples(input int count, input int noise);
		int i;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < noise) send_word(read_word());
			if ($urandom_range(0, 199) < noise) write_reg(CFG_WINDOW, $urandom_range(0, 1));
			send_word(sample_word());
		end
	endtask

	// Read out elements; now and then slip in an out-of-phase write.
	task automatic unload_plane(input int count, input int noise);
		int i;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < noise) send_word(sample_word());
			if ($urandom_range(0, 199) < noise) write_reg(CFG_WINDOW, $urandom_range(0, 1));
			send_word(read_word());
		end
	endtask

	initial begin : stimulus
		int start;
		int group;
		int ext_idx;
		int new_spc;
		int new_cpf;
		int sel;
		int planes;
		int p;
		int fate;
		int total;
		bit dirty;
		bit random_hold;
		bit use_ext;
		int ext_spc [4] = '{511, 1, 256, 2};
		int ext_cpf [4] = '{1, 255, 1, 128};

		// Drive every input to a known value before reset lifts.
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_SAMPLES;
		cfg_data     = '0;
		din_if.valid = 1'b0;
		din_if.data  = '0;
		gaps_on      = 1'b1;
		burst_left   = 0;
		words_sent   = 0;
		cur_spc      = MaxSamples;
		cur_cpf      = MaxChirps;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ---- Directed part ----
		// Reset sizes are 256 x 128 and nothing is loaded: a read is out of phase.
		send_word(read_word());

		// Small non-square plane so the transpose order is visible.
		write_reg(CFG_SAMPLES, 2);
		write_reg(CFG_CHIRPS, 3);
		write_reg(CFG_WINDOW, 1);
		// Unity weight on both extremes, half-up rounding on -1 and +1, zero weight.
		send_word(make_write(16'sh7fff, 16'sh8000, WeightOne));
		send_word(make_write(-16'sh0001, 16'sh0001, 16'd16384));
		send_word(make_write(16'sh8000, 16'sh7fff, 16'd0));
		// Turn the window off mid-plane: later samples pass unscaled.
		write_reg(CFG_WINDOW, 0);
		send_word(make_write(16'sh8000, 16'sh7fff, WeightOne));
		send_word(make_write(16'sh0000, -16'sh0001, 16'h7fff));
		send_word(sample_word());
		// Plane is full: a write now is out of phase.
		send_word(sample_word());
		unload_plane(6, 0);
		// Back in loading after the last element: a read is out of phase again.
		send_word(read_word());

		// Zero sizes count as one: a one-element plane.
		write_reg(CFG_SAMPLES, 0);
		write_reg(CFG_CHIRPS, 0);
		send_word(sample_word());
		send_word(read_word());

		// ---- Back-pressure ----
		// Keep offering reads while the receiver holds off, so the block stalls
		// its input; then pause until the plane has drained.
		write_reg(CFG_SAMPLES, 4);
		write_reg(CFG_CHIRPS, 4);
		gaps_on = 1'b0;
		load_samples(16, 0);
		hold_reqs++;
		unload_plane(16, 0);
		settle();
		gaps_on = 1'b1;

		// ---- Random part ----
		// Mostly well-formed planes with random content, some abandoned part way,
		// with out-of-phase words sprinkled in. Every third group early on runs
		// one plane of one of the extreme size settings.
		start       = words_sent;
		group       = 0;
		ext_idx     = 0;
		dirty       = 1'b0;
		random_hold = 1'b0;
		while (words_sent - start < RandomWords) begin
			use_ext = (group % 3 == 1) && (ext_idx < 4);
			if (use_ext) begin
				new_spc = ext_spc[ext_idx];
				new_cpf = ext_cpf[ext_idx];
				ext_idx++;
				sel = 0;
			end else begin
				new_spc = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
				new_cpf = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
				// 0: both sizes, 1: samples only, 2: chirps only, 3: keep sizes.
				sel = $urandom_range(0, 3);
				if (dirty && sel == 3) sel = 0;
			end
			if (sel == 0 || sel == 1) write_reg(CFG_SAMPLES, new_spc);
			if (sel == 0 || sel == 2) write_reg(CFG_CHIRPS, new_cpf);
			dirty = 1'b0;
			if ($urandom_range(0, 1)) write_reg(CFG_WINDOW, $urandom_range(0, 1));

			gaps_on = ($urandom_range(0, 2) != 0);
			total   = eff_size(cur_spc, MaxSamples) * eff_size(cur_cpf, MaxChirps);
			planes  = use_ext ? 1 : $urandom_range(1, 3);
			for (p = 0; p < planes; p++) begin
				// Stop at a plane boundary once the word budget is spent.
				if (words_sent - start >= RandomWords) break;
				fate = $urandom_range(0, 99);
				if (fate < 7) begin
					// Abandon during loading; the next group restarts the plane.
					load_samples($urandom_range(0, total - 1), 4);
					dirty = 1'b1;
					break;
				end
				load_samples(total, 4);
				if ($urandom_range(0, 19) == 0) settle();
				if (!random_hold && words_sent - start > RandomWords / 2) begin
					hold_reqs++;
					random_hold = 1'b1;
				end
				if (fate < 14) begin
					// Abandon during read-out.
					unload_plane($urandom_range(0, total - 1), 4);
					dirty = 1'b1;
					break;
				end
				unload_plane(total, 4);
			end
			group++;
		end

		// Wait for the last result words, then a few more cycles for strays.
		settle();
		repeat (DrainCycles) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
design/wct_pkg.sv
design/wct_in_if.sv
design/wct_out_if.sv
design/wct_ram.sv
design/wct_ctrl.sv
design/wct_dp.sv
design/windowed_corner_turn.sv
dv/windowed_corner_turn_checker.sv
dv/windowed_corner_turn_tb.sv
